>>> rtl/core/oqks_pkg.sv
// ----------------------------------------------------------------------------
// Ordered queue with key search: shared types and constants
// Operation codes and the command and status structs between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package oqks_pkg;

    localparam logic [2:0] OP_PUSH       = 3'd0;
    localparam logic [2:0] OP_POP        = 3'd1;
    localparam logic [2:0] OP_UPDATE_KEY = 3'd2;
    localparam logic [2:0] OP_REMOVE_NAME  = 3'd3;
    localparam logic [2:0] OP_REMOVE_TOPIC = 3'd4;
    localparam logic [2:0] OP_LIST_TOPIC   = 3'd5;

    typedef struct packed {
        logic load;       // capture the input transaction
        logic push;       // write the captured entry at the tail
        logic scan_start; // set the scan index to zero
        logic scan_next;  // advance the scan index
        logic update;     // rewrite topic and question at the scan index
        logic shift;      // copy the entry after the scan index down by one
        logic shrink;     // drop the tail slot and count a visit
    } t_cmd;

    typedef struct packed {
        logic scan_end;   // scan index has reached the fill count
        logic shift_end;  // scan index is at the last filled slot
        logic key_hit;
        logic name_hit;
        logic topic_hit;
        logic full;
        logic empty;
        logic name_empty;
    } t_status;

endpackage

>>> rtl/core/oqks_datapath.sv
// ----------------------------------------------------------------------------
// Ordered queue with key search: datapath
// Slot storage, the scan index, the match compares and the counters.
// ----------------------------------------------------------------------------
module oqks_datapath #(
    parameter int QUEUE_DEPTH = 16,
    parameter int NAME_BYTES  = 8,
    parameter int IDX_W       = 4,
    parameter int CNT_W       = 5
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  oqks_pkg::t_cmd     i_cmd,
    output oqks_pkg::t_status  o_status,
    input  logic [2:0]         i_operation,
    input  logic [30:0]        i_key,
    input  logic [63:0]        i_name,
    input  logic [3:0]         i_topic,
    input  logic [31:0]        i_question,
    output logic [2:0]         o_op,
    output logic [CNT_W-1:0]   o_fill,
    output logic [31:0]        o_visit,
    output logic [30:0]        o_cur_key,
    output logic [31:0]        o_cur_ticket
);

    logic [30:0] r_key [QUEUE_DEPTH];
    logic [63:0] r_name [QUEUE_DEPTH];
    logic [3:0]  r_topic [QUEUE_DEPTH];
    logic [31:0] r_question [QUEUE_DEPTH];
    logic [31:0] r_ticket [QUEUE_DEPTH];

    logic [2:0]  r_op;
    logic [30:0] r_in_key;
    logic [63:0] r_in_name;
    logic [3:0]  r_in_topic;
    logic [31:0] r_in_question;
    logic [CNT_W-1:0] r_fill;
    logic [CNT_W:0]   r_idx;
    logic [31:0] r_visit;

    logic [IDX_W-1:0] w_idx;
    logic [IDX_W-1:0] w_nxt;
    logic [IDX_W-1:0] w_tail;
    logic [63:0] w_in_mask;
    logic [63:0] w_slot_mask;
    logic [63:0] w_stored;

    assign w_idx  = r_idx[IDX_W-1:0];
    assign w_nxt  = IDX_W'(r_idx + 1'b1);
    assign w_tail = r_fill[IDX_W-1:0];

    always_comb begin
        logic run_in;
        logic run_slot;
        run_in   = 1'b1;
        run_slot = 1'b1;
        w_in_mask   = '0;
        w_slot_mask = '0;
        for (int b = 0; b < 8; b++) begin
            if (b < NAME_BYTES) begin
                run_in = run_in && (i_name[8*b +: 8] != 8'd0);
                if (run_in) begin
                    w_in_mask[8*b +: 8] = 8'hFF;
                end
                run_slot = run_slot && (r_name[w_idx][8*b +: 8] != 8'd0);
                if (run_slot) begin
                    w_slot_mask[8*b +: 8] = 8'hFF;
                end
            end
        end
        w_stored = i_name & w_in_mask;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_visit <= '0;
            r_idx   <= '0;
            r_op    <= '0;
        end else begin
            if (i_cmd.load) begin
                r_op          <= i_operation;
                r_in_key      <= i_key;
                r_in_name     <= i_name;
                r_in_topic    <= i_topic;
                r_in_question <= i_question;
            end
            if (i_cmd.push) begin
                r_key[w_tail]      <= i_key;
                r_name[w_tail]     <= w_stored;
                r_topic[w_tail]    <= i_topic;
                r_question[w_tail] <= i_question;
                r_ticket[w_tail]   <= r_visit;
                r_fill  <= r_fill + 1'b1;
                r_visit <= r_visit + 32'd1;
            end
            if (i_cmd.scan_start) begin
                r_idx <= '0;
            end else if (i_cmd.scan_next) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.update) begin
                r_topic[w_idx]    <= r_in_topic;
                r_question[w_idx] <= r_in_question;
            end
            if (i_cmd.shift) begin
                r_key[w_idx]      <= r_key[w_nxt];
                r_name[w_idx]     <= r_name[w_nxt];
                r_topic[w_idx]    <= r_topic[w_nxt];
                r_question[w_idx] <= r_question[w_nxt];
                r_ticket[w_idx]   <= r_ticket[w_nxt];
            end
            if (i_cmd.shrink) begin
                r_fill  <= r_fill - 1'b1;
                r_visit <= r_visit + 32'd1;
            end
        end
    end

    always_comb begin
        o_status.scan_end   = (r_idx >= (CNT_W+1)'(r_fill));
        o_status.shift_end  = ((r_idx + 1'b1) >= (CNT_W+1)'(r_fill));
        o_status.key_hit    = (r_key[w_idx] == r_in_key);
        o_status.name_hit   = ((r_in_name & w_slot_mask) == r_name[w_idx]);
        o_status.topic_hit  = (r_topic[w_idx] == r_in_topic)
                              && (r_question[w_idx] == r_in_question);
        o_status.full       = (r_fill >= CNT_W'(QUEUE_DEPTH));
        o_status.empty      = (r_fill == '0);
        o_status.name_empty = (i_name[7:0] == 8'd0);
    end

    assign o_op         = r_op;
    assign o_fill       = r_fill;
    assign o_visit      = r_visit;
    assign o_cur_key    = r_key[w_idx];
    assign o_cur_ticket = r_ticket[w_idx];

endmodule

>>> rtl/core/oqks_ctrl.sv
// ----------------------------------------------------------------------------
// Ordered queue with key search: controller
// Sequences scans, gap closing and result transactions for each operation.
// ----------------------------------------------------------------------------
module oqks_ctrl #(
    parameter int CNT_W = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [2:0]        i_operation,
    output oqks_pkg::t_cmd    o_cmd,
    input  oqks_pkg::t_status i_status,
    input  logic [2:0]        i_op,
    input  logic [CNT_W-1:0]  i_fill,
    input  logic [31:0]       i_visit,
    input  logic [30:0]       i_cur_key,
    input  logic [31:0]       i_cur_ticket,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_status,
    output logic [4:0]        o_occupancy,
    output logic [31:0]       o_visited,
    output logic              o_in_progress,
    output logic              o_match_valid,
    output logic [30:0]       o_match_key,
    output logic [31:0]       o_match_ticket,
    output logic              o_last
);

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_SHIFT, S_REPORT, S_HOLD, S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_ok, n_ok;
    logic   r_pkey_vld, n_pkey_vld;
    logic [30:0] r_pkey, n_pkey;
    logic [31:0] r_ptkt, n_ptkt;
    logic   r_fail, n_fail;
    logic   r_tkt_sel, n_tkt_sel;
    logic [31:0] r_tkt, n_tkt;

    always_comb begin
        o_cmd      = '0;
        n_state    = r_state;
        n_ok       = r_ok;
        n_pkey_vld = r_pkey_vld;
        n_pkey     = r_pkey;
        n_ptkt     = r_ptkt;
        n_fail     = r_fail;
        n_tkt_sel  = r_tkt_sel;
        n_tkt      = r_tkt;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load       = 1'b1;
                    o_cmd.scan_start = 1'b1;
                    n_ok       = 1'b0;
                    n_pkey_vld = 1'b0;
                    n_fail     = 1'b1;
                    n_tkt_sel  = 1'b0;
                    case (i_operation)
                        oqks_pkg::OP_PUSH: begin
                            if (!i_status.name_empty && !i_status.full) begin
                                o_cmd.push = 1'b1;
                                n_fail     = 1'b0;
                                n_tkt_sel  = 1'b1;
                                n_tkt      = i_visit;
                            end
                            n_state = S_DONE;
                        end
                        oqks_pkg::OP_POP: begin
                            if (!i_status.empty) begin
                                n_fail  = 1'b0;
                                n_state = S_SHIFT;
                            end else begin
                                n_state = S_DONE;
                            end
                        end
                        oqks_pkg::OP_UPDATE_KEY, oqks_pkg::OP_REMOVE_NAME,
                        oqks_pkg::OP_REMOVE_TOPIC, oqks_pkg::OP_LIST_TOPIC: begin
                            n_state = S_SCAN;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (i_status.scan_end) begin
                    case (i_op)
                        oqks_pkg::OP_REMOVE_TOPIC: n_fail = !r_ok;
                        oqks_pkg::OP_LIST_TOPIC:   n_fail = 1'b0;
                        default:                   n_fail = 1'b1;
                    endcase
                    n_state = (i_op == oqks_pkg::OP_LIST_TOPIC) ? S_REPORT : S_DONE;
                end else begin
                    case (i_op)
                        oqks_pkg::OP_UPDATE_KEY: begin
                            if (i_status.key_hit) begin
                                o_cmd.update = 1'b1;
                                n_fail  = 1'b0;
                                n_state = S_DONE;
                            end else begin
                                o_cmd.scan_next = 1'b1;
                            end
                        end
                        oqks_pkg::OP_REMOVE_NAME: begin
                            if (i_status.name_hit) begin
                                n_fail  = 1'b0;
                                n_state = S_SHIFT;
                            end else begin
                                o_cmd.scan_next = 1'b1;
                            end
                        end
                        oqks_pkg::OP_REMOVE_TOPIC: begin
                            if (i_status.topic_hit) begin
                                n_ok    = 1'b1;
                                n_state = S_SHIFT;
                            end else begin
                                o_cmd.scan_next = 1'b1;
                            end
                        end
                        default: begin
                            if (i_status.topic_hit && r_pkey_vld) begin
                                n_state = S_HOLD;
                            end else begin
                                o_cmd.scan_next = 1'b1;
                                if (i_status.topic_hit) begin
                                    n_pkey_vld = 1'b1;
                                    n_pkey     = i_cur_key;
                                    n_ptkt     = i_cur_ticket;
                                end
                            end
                        end
                    endcase
                end
            end
            S_SHIFT: begin
                if (i_status.shift_end) begin
                    o_cmd.shrink = 1'b1;
                    if (i_op == oqks_pkg::OP_REMOVE_TOPIC) begin
                        o_cmd.scan_start = 1'b1;
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    o_cmd.shift     = 1'b1;
                    o_cmd.scan_next = 1'b1;
                end
            end
            S_HOLD: begin
                if (!r_valid || i_ready) begin
                    o_cmd.scan_next = 1'b1;
                    n_pkey  = i_cur_key;
                    n_ptkt  = i_cur_ticket;
                    n_state = S_SCAN;
                end
            end
            S_REPORT, S_DONE: begin
                if (!r_valid || i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Result register: shown while r_valid, replaced only after acceptance.
    logic r_valid;
    logic w_emit;
    logic w_emit_prev;
    assign w_emit      = (r_state == S_REPORT || r_state == S_DONE) && (!r_valid || i_ready);
    assign w_emit_prev = (r_state == S_HOLD) && (!r_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_valid    <= 1'b0;
            r_ok       <= 1'b0;
            r_pkey_vld <= 1'b0;
            r_fail     <= 1'b0;
            r_tkt_sel  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_ok       <= n_ok;
            r_pkey_vld <= n_pkey_vld;
            r_pkey     <= n_pkey;
            r_ptkt     <= n_ptkt;
            r_fail     <= n_fail;
            r_tkt_sel  <= n_tkt_sel;
            r_tkt      <= n_tkt;
            if (w_emit_prev) begin
                r_valid        <= 1'b1;
                o_status       <= 1'b0;
                o_match_valid  <= 1'b1;
                o_match_key    <= r_pkey;
                o_match_ticket <= r_ptkt;
                o_last         <= 1'b0;
                o_occupancy    <= 5'(i_fill);
                o_visited      <= i_visit;
                o_in_progress  <= (i_fill != '0);
            end else if (w_emit) begin
                r_valid       <= 1'b1;
                o_status      <= r_fail;
                o_last        <= 1'b1;
                o_occupancy   <= 5'(i_fill);
                o_visited     <= i_visit;
                o_in_progress <= (i_fill != '0);
                if (r_state == S_REPORT && r_pkey_vld) begin
                    o_match_valid  <= 1'b1;
                    o_match_key    <= r_pkey;
                    o_match_ticket <= r_ptkt;
                end else begin
                    o_match_valid  <= 1'b0;
                    o_match_key    <= '0;
                    o_match_ticket <= r_tkt_sel ? r_tkt : 32'd0;
                end
            end else if (r_valid && i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_valid;

endmodule

>>> rtl/core/ordered_queue_with_key_search_core.sv
// Push and undefined codes go straight to the result; searches walk the filled slots;
// removals that close a gap also move each later slot down by one, and remove-by-topic
// rescans from slot zero after each removal. One operation at a time; the slot scan
// is the limiting loop. A listing gives one result per match, or one if none match.
// Reset (synchronous, active low) empties the queue and clears the visit count.
// ----------------------------------------------------------------------------
// Ordered queue with key search: top level
// Bounded ordered queue with push, pop, search, update and removal.
// ----------------------------------------------------------------------------
module ordered_queue_with_key_search_core #(
    parameter int QUEUE_DEPTH = 16,
    parameter int NAME_BYTES  = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_operation,
    input  logic [30:0] i_key,
    input  logic [63:0] i_name,
    input  logic [3:0]  i_topic,
    input  logic [31:0] i_question,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_status,
    output logic [4:0]  o_occupancy,
    output logic [31:0] o_visited,
    output logic        o_in_progress,
    output logic        o_match_valid,
    output logic [30:0] o_match_key,
    output logic [31:0] o_match_ticket,
    output logic        o_last
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    oqks_pkg::t_cmd    w_cmd;
    oqks_pkg::t_status w_status;
    logic [2:0]        w_op;
    logic [CNT_W-1:0]  w_fill;
    logic [31:0]       w_visit;
    logic [30:0]       w_cur_key;
    logic [31:0]       w_cur_ticket;

    oqks_datapath #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .NAME_BYTES (NAME_BYTES),
        .IDX_W      (IDX_W),
        .CNT_W      (CNT_W)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_operation (i_operation),
        .i_key       (i_key),
        .i_name      (i_name),
        .i_topic     (i_topic),
        .i_question  (i_question),
        .o_op        (w_op),
        .o_fill      (w_fill),
        .o_visit     (w_visit),
        .o_cur_key   (w_cur_key),
        .o_cur_ticket(w_cur_ticket)
    );

    oqks_ctrl #(
        .CNT_W(CNT_W)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_operation   (i_operation),
        .o_cmd         (w_cmd),
        .i_status      (w_status),
        .i_op          (w_op),
        .i_fill        (w_fill),
        .i_visit       (w_visit),
        .i_cur_key     (w_cur_key),
        .i_cur_ticket  (w_cur_ticket),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_occupancy   (o_occupancy),
        .o_visited     (o_visited),
        .o_in_progress (o_in_progress),
        .o_match_valid (o_match_valid),
        .o_match_key   (o_match_key),
        .o_match_ticket(o_match_ticket),
        .o_last        (o_last)
    );

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// Ordered queue with key search: testbench
// Drives push, pop, update, removal and listing transactions with random
// gaps and stalls, predicts every result with a scoreboard that keeps its
// own copy of the queue, and compares each result field by field.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int DEPTH = 16;
    localparam int NBYTES = 8;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic        status;
        logic [4:0]  occupancy;
        logic [31:0] visited;
        logic        in_progress;
        logic        match_valid;
        logic [30:0] match_key;
        logic [31:0] match_ticket;
        logic        last;
    } t_result;

    class queue_scoreboard;
        logic [30:0] q_key[DEPTH];
        logic [63:0] q_name[DEPTH];
        logic [3:0]  q_topic[DEPTH];
        logic [31:0] q_question[DEPTH];
        logic [31:0] q_ticket[DEPTH];
        int          fill;
        logic [31:0] visits;
        t_result     pending[$];
        int          errors;

        function new();
            fill = 0;
            visits = 0;
            errors = 0;
        endfunction

        function int name_len(logic [63:0] nm);
            int n;
            n = 0;
            while (n < NBYTES && nm[8*n +: 8] != 8'd0) n++;
            return n;
        endfunction

        function logic [63:0] len_mask(int len);
            return (len >= 8) ? '1 : ((64'd1 << (8 * len)) - 64'd1);
        endfunction

        function void add(logic st, logic mv, logic [30:0] k, logic [31:0] t, logic lst);
            t_result r;
            r.status = st;
            r.occupancy = fill[4:0];
            r.visited = visits;
            r.in_progress = (fill > 0);
            r.match_valid = mv;
            r.match_key = k;
            r.match_ticket = t;
            r.last = lst;
            pending.push_back(r);
        endfunction

        function void drop(int idx);
            for (int j = idx; j + 1 < fill; j++) begin
                q_key[j] = q_key[j+1];
                q_name[j] = q_name[j+1];
                q_topic[j] = q_topic[j+1];
                q_question[j] = q_question[j+1];
                q_ticket[j] = q_ticket[j+1];
            end
            fill--;
            visits++;
        endfunction

        function void note_input(logic [2:0] op, logic [30:0] k, logic [63:0] nm,
                                 logic [3:0] tp, logic [31:0] qn);
            int len;
            int hits;
            int i;
            bit done;
            logic [31:0] t;
            done = 0;
            hits = 0;
            case (op)
                oqks_pkg::OP_PUSH: begin
                    len = name_len(nm);
                    if (len == 0 || fill >= DEPTH) begin
                        add(1, 0, 0, 0, 1);
                    end else begin
                        t = visits;
                        q_key[fill] = k;
                        q_name[fill] = nm & len_mask(len);
                        q_topic[fill] = tp;
                        q_question[fill] = qn;
                        q_ticket[fill] = t;
                        fill++;
                        visits++;
                        add(0, 0, 0, t, 1);
                    end
                end
                oqks_pkg::OP_POP: begin
                    if (fill == 0) begin
                        add(1, 0, 0, 0, 1);
                    end else begin
                        drop(0);
                        add(0, 0, 0, 0, 1);
                    end
                end
                oqks_pkg::OP_UPDATE_KEY: begin
                    for (i = 0; i < fill && !done; i++) begin
                        if (q_key[i] == k) begin
                            q_topic[i] = tp;
                            q_question[i] = qn;
                            done = 1;
                        end
                    end
                    add(!done, 0, 0, 0, 1);
                end
                oqks_pkg::OP_REMOVE_NAME: begin
                    for (i = 0; i < fill && !done; i++) begin
                        if ((nm & len_mask(name_len(q_name[i]))) == q_name[i]) begin
                            drop(i);
                            done = 1;
                        end
                    end
                    add(!done, 0, 0, 0, 1);
                end
                oqks_pkg::OP_REMOVE_TOPIC: begin
                    i = 0;
                    while (i < fill) begin
                        if (q_topic[i] == tp && q_question[i] == qn) begin
                            drop(i);
                            hits++;
                        end else begin
                            i++;
                        end
                    end
                    add(hits == 0, 0, 0, 0, 1);
                end
                oqks_pkg::OP_LIST_TOPIC: begin
                    for (i = 0; i < fill; i++) begin
                        if (q_topic[i] == tp && q_question[i] == qn) begin
                            add(0, 1, q_key[i], q_ticket[i], 0);
                            hits++;
                        end
                    end
                    if (hits == 0) add(0, 0, 0, 0, 1);
                    else pending[$].last = 1;
                end
                default: add(1, 0, 0, 0, 1);
            endcase
        endfunction

        function void check_result(t_result got);
            t_result exp;
            if (pending.size() == 0) begin
                $error("unexpected result transaction");
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.status !== exp.status) begin
                $error("status: expected %0d actual %0d", exp.status, got.status);
                errors++;
            end
            if (got.occupancy !== exp.occupancy) begin
                $error("occupancy: expected %0d actual %0d", exp.occupancy, got.occupancy);
                errors++;
            end
            if (got.visited !== exp.visited) begin
                $error("visited: expected %0d actual %0d", exp.visited, got.visited);
                errors++;
            end
            if (got.in_progress !== exp.in_progress) begin
                $error("in_progress: expected %0d actual %0d", exp.in_progress,
                       got.in_progress);
                errors++;
            end
            if (got.match_valid !== exp.match_valid) begin
                $error("match_valid: expected %0d actual %0d", exp.match_valid,
                       got.match_valid);
                errors++;
            end
            if (got.match_key !== exp.match_key) begin
                $error("match_key: expected %0h actual %0h", exp.match_key, got.match_key);
                errors++;
            end
            if (got.match_ticket !== exp.match_ticket) begin
                $error("match_ticket: expected %0h actual %0h", exp.match_ticket,
                       got.match_ticket);
                errors++;
            end
            if (got.last !== exp.last) begin
                $error("last: expected %0d actual %0d", exp.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [2:0]  i_operation;
    logic [30:0] i_key;
    logic [63:0] i_name;
    logic [3:0]  i_topic;
    logic [31:0] i_question;
    logic        o_valid;
    logic        i_ready;
    logic        o_status;
    logic [4:0]  o_occupancy;
    logic [31:0] o_visited;
    logic        o_in_progress;
    logic        o_match_valid;
    logic [30:0] o_match_key;
    logic [31:0] o_match_ticket;
    logic        o_last;

    queue_scoreboard board;
    int          cycle_count;
    bit          stim_done;

    logic [30:0] used_keys[$];
    logic [63:0] used_names[$];
    logic [3:0]  used_topics[$];
    logic [31:0] used_questions[$];

    ordered_queue_with_key_search_core uut (.*);

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [63:0] rand_name();
        logic [63:0] nm;
        int len;
        nm = {$urandom, $urandom};
        len = $urandom_range(0, 8);
        if ($urandom_range(0, 3) != 0) nm = nm & ((len >= 8) ? '1 : ((64'd1 << (8*len)) - 1));
        return nm;
    endfunction

    task automatic send(logic [2:0] op, logic [30:0] k, logic [63:0] nm,
                        logic [3:0] tp, logic [31:0] qn);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_operation <= op;
        i_key <= k;
        i_name <= nm;
        i_topic <= tp;
        i_question <= qn;
        do @(posedge i_clk); while (!o_ready);
        board.note_input(op, k, nm, tp, qn);
        if (op == oqks_pkg::OP_PUSH) begin
            used_keys.push_back(k);
            used_names.push_back(nm);
            used_topics.push_back(tp);
            used_questions.push_back(qn);
        end
        @(negedge i_clk);
    endtask

    task automatic send_random();
        int r;
        int pick;
        logic [30:0] k;
        logic [63:0] nm;
        logic [3:0]  tp;
        logic [31:0] qn;
        r = $urandom_range(0, 99);
        k = 31'($urandom);
        nm = rand_name();
        tp = 4'($urandom_range(0, 3));
        qn = $urandom_range(0, 2);
        if ($urandom_range(0, 9) == 0) begin
            tp = 4'($urandom);
            qn = $urandom;
        end
        if (used_keys.size() > 0 && $urandom_range(0, 2) != 0) begin
            pick = $urandom_range(0, used_keys.size() - 1);
            k = used_keys[pick];
            tp = used_topics[pick];
            qn = used_questions[pick];
            if ($urandom_range(0, 1) != 0) nm = used_names[pick];
        end
        if (r < 38) send(oqks_pkg::OP_PUSH, k, nm, tp, qn);
        else if (r < 50) send(oqks_pkg::OP_POP, k, nm, tp, qn);
        else if (r < 62) send(oqks_pkg::OP_UPDATE_KEY, k, nm, 4'($urandom_range(0, 3)), qn);
        else if (r < 74) send(oqks_pkg::OP_REMOVE_NAME, k, nm, tp, qn);
        else if (r < 82) send(oqks_pkg::OP_REMOVE_TOPIC, k, nm, tp, qn);
        else if (r < 97) send(oqks_pkg::OP_LIST_TOPIC, k, nm, tp, qn);
        else send(3'($urandom_range(6, 7)), k, nm, tp, qn);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            board.check_result('{o_status, o_occupancy, o_visited, o_in_progress,
                                 o_match_valid, o_match_key, o_match_ticket, o_last});
        end
    end

    initial begin
        int stall;
        i_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                stall--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                if (!stim_done || $urandom_range(0, 3) == 0) stall = gap_len();
                if (cycle_count > 150000 && cycle_count < 180000) stall = 0;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial begin
        board = new();
        cycle_count = 0;
        stim_done = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_operation = oqks_pkg::OP_PUSH;
        i_key = '0;
        i_name = '0;
        i_topic = '0;
        i_question = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send(oqks_pkg::OP_POP, 0, 0, 0, 0);
        send(oqks_pkg::OP_PUSH, 31'h7fffffff, 64'd0, 4'hf, 32'hffffffff);
        send(oqks_pkg::OP_PUSH, 31'h7fffffff, '1, 4'hf, 32'hffffffff);
        send(oqks_pkg::OP_PUSH, 31'd0, 64'h0000_0000_0000_0041, 4'h0, 32'd0);
        send(oqks_pkg::OP_PUSH, 31'd5, 64'hff00_0000_0000_4241, 4'h0, 32'd0);
        send(oqks_pkg::OP_LIST_TOPIC, 0, 0, 4'h0, 32'd0);
        send(oqks_pkg::OP_LIST_TOPIC, 0, 0, 4'h3, 32'd7);
        send(oqks_pkg::OP_UPDATE_KEY, 31'd5, 0, 4'hf, 32'hffffffff);
        send(oqks_pkg::OP_UPDATE_KEY, 31'd99, 0, 4'h1, 32'd1);
        send(oqks_pkg::OP_REMOVE_NAME, 0, 64'h0000_0000_0043_4241, 0, 0);
        send(oqks_pkg::OP_REMOVE_NAME, 0, 64'h0000_0000_0000_0058, 0, 0);
        send(oqks_pkg::OP_REMOVE_TOPIC, 0, 0, 4'hf, 32'hffffffff);
        send(oqks_pkg::OP_REMOVE_TOPIC, 0, 0, 4'h9, 32'd9);
        send(3'd6, 0, 0, 0, 0);
        send(3'd7, 0, 0, 0, 0);
        for (int n = 0; n < 17; n++) begin
            send(oqks_pkg::OP_PUSH, 31'(n), 64'h0000_0000_0000_0031 + 64'(n), 4'h2, 32'd2);
        end
        send(oqks_pkg::OP_LIST_TOPIC, 0, 0, 4'h2, 32'd2);
        send(oqks_pkg::OP_REMOVE_TOPIC, 0, 0, 4'h2, 32'd2);
        send(oqks_pkg::OP_POP, 0, 0, 0, 0);
        send(oqks_pkg::OP_POP, 0, 0, 0, 0);

        for (int n = 0; n < 250; n++) send_random();
        i_valid <= 1'b0;
        stim_done = 1;

        while (board.pending.size() > 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end
endmodule

>>> sim.f
rtl/core/oqks_pkg.sv
rtl/core/oqks_datapath.sv
rtl/core/oqks_ctrl.sv
rtl/core/ordered_queue_with_key_search_core.sv
test/tb_top.sv
